### src/mrfc_pkg.sv
// Shared types, constants and helper functions for the meter response frame checker.
`default_nettype none

package mrfc_pkg;

  localparam int COUNT_W       = 8;
  localparam int MAX_FRAME     = 255;
  localparam int PAYLOAD_BYTES = 16;
  localparam int PAY_IDX_W     = $clog2(PAYLOAD_BYTES);
  localparam int VALUE_W       = 30;
  localparam int KIND_W        = 3;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QCOUNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_LSB    = 16'h0001;
  localparam logic [7:0]  FIELD_MASK = 8'h3F;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_SIZE = 2'd1,
    STATUS_BAD_CRC  = 2'd2
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ONE_BYTE   = 3'd0,
    KIND_THREE_BYTE = 3'd1,
    KIND_THREE_X3   = 3'd2,
    KIND_FOUR_X3    = 3'd3,
    KIND_FOUR_X4    = 3'd4
  } frame_kind_t;

  // One classified byte, passed from the front end to the back end.
  typedef struct packed {
    logic [7:0]           data;
    logic                 last;
    logic                 crc_en;    // byte position >= 2: oldest trailing byte enters CRC
    logic                 store_en;  // byte position 1..PAYLOAD_BYTES
    logic [PAY_IDX_W-1:0] store_idx;
    logic [COUNT_W-1:0]   len;       // count including this byte, saturated
  } byte_item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_LSB) != 16'h0000) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [COUNT_W-1:0] kind_size(input logic [KIND_W-1:0] kind);
    logic [COUNT_W-1:0] s;
    case (kind)
      KIND_ONE_BYTE:   s = COUNT_W'(4);
      KIND_THREE_BYTE: s = COUNT_W'(6);
      KIND_THREE_X3:   s = COUNT_W'(12);
      KIND_FOUR_X3:    s = COUNT_W'(15);
      KIND_FOUR_X4:    s = COUNT_W'(19);
      default:         s = '0;
    endcase
    return s;
  endfunction

  // 3-byte field b0 b1 b2 -> {b0[5:0], b2, b1}
  function automatic logic [VALUE_W-1:0] dec3(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2);
    logic [7:0] hi;
    hi = b0 & FIELD_MASK;
    return VALUE_W'({hi[5:0], b2, b1});
  endfunction

  // 4-byte field b0 b1 b2 b3 -> {b1[5:0], b0, b3, b2}
  function automatic logic [VALUE_W-1:0] dec4(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3);
    logic [7:0] hi;
    hi = b1 & FIELD_MASK;
    return {hi[5:0], b0, b3, b2};
  endfunction

endpackage

`default_nettype wire

### src/meter_response_frame_checker.sv
// Top level of the meter response frame checker: config register and front/queue/back.
//
//  channel  dir  handshake           payload (low bit up)
//  s_*      in   s_tvalid/s_tready   s_tdata[7:0] data_byte, s_tlast last_byte
//  m_*      out  m_tvalid/m_tready   m_tdata: status, frame_length, value_a..value_d
//  cfg_*    in   cfg_valid/cfg_ready cfg_data[2:0] frame_kind (reset 2)
//
// One byte per cycle sustained while no last byte waits on an untaken result; the
// byte-wide CRC update sits in the back end, between the queue head and the CRC register.
// A result appears in the cycle after the last byte leaves the queue; the front end
// accepts bytes while a result waits on m_tready.
// Only a last byte stalls in the back end, behind an untaken result; the two-entry
// queue then fills and drops s_tready.
// Synchronous reset clears byte position, CRC, trailing bytes, queue and result valid.
// Configuration is taken at any time (cfg_ready is always high); change it only while idle.
`default_nettype none

module meter_response_frame_checker
  import mrfc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  // data_byte [7:0]
  input  wire logic [7:0]    s_tdata,
  input  wire logic          s_tlast,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // status [1:0], frame_length [9:2], value_a [39:10], value_b [69:40],
  // value_c [99:70], value_d [129:100], zero [135:130]
  output logic [135:0]       m_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // frame_kind [2:0]
  input  wire logic [KIND_W-1:0] cfg_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready
);

  logic [KIND_W-1:0]  frame_kind;

  logic               push;
  byte_item_t         push_item;
  logic               q_push_ready;
  logic               q_valid;
  byte_item_t         q_item;
  logic               pop;

  status_t            out_status;
  logic [COUNT_W-1:0] out_len;
  logic [VALUE_W-1:0] out_va, out_vb, out_vc, out_vd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind <= KIND_THREE_X3;
    end else if (cfg_valid && cfg_ready) begin
      frame_kind <= cfg_data;
    end
  end

  mrfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_push_ready)
  );

  mrfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (q_push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (pop)
  );

  mrfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .frame_kind (frame_kind),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_len    (out_len),
    .out_va     (out_va),
    .out_vb     (out_vb),
    .out_vc     (out_vc),
    .out_vd     (out_vd)
  );

  assign m_tdata = {6'b000000, out_vd, out_vc, out_vb, out_va, out_len, out_status};

endmodule

`default_nettype wire

### src/mrfc_front.sv
// Front end: accepts frame bytes, tracks byte position, tags each byte for the back end.
`default_nettype none

module mrfc_front
  import mrfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data,
  input  wire logic       in_last,
  output logic            push,
  output byte_item_t      push_item,
  input  wire logic       q_ready
);

  logic [COUNT_W-1:0] pos;
  logic [COUNT_W-1:0] pos_next;
  logic               accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign push     = accept;

  always_comb begin
    push_item.data      = in_data;
    push_item.last      = in_last;
    push_item.crc_en    = (pos >= COUNT_W'(2));
    push_item.store_en  = (pos >= COUNT_W'(1)) && (pos <= COUNT_W'(PAYLOAD_BYTES));
    push_item.store_idx = PAY_IDX_W'(pos - COUNT_W'(1));
    push_item.len       = (pos == COUNT_W'(MAX_FRAME)) ? pos : pos + COUNT_W'(1);
    pos_next = pos;
    if (accept) begin
      pos_next = in_last ? '0 : push_item.len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

`ifndef SYNTHESIS
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> pos == '0)
    else $error("byte position not cleared after last byte");
`endif

endmodule

`default_nettype wire

### src/mrfc_queue.sv
// Two-entry queue of tagged bytes between front and back ends.
`default_nettype none

module mrfc_queue
  import mrfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire byte_item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output byte_item_t      pop_item,
  input  wire logic       pop
);

  byte_item_t            slot [QUEUE_DEPTH];
  logic [QCOUNT_W-1:0]   count;

  assign push_ready = (count != QCOUNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slot[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + QCOUNT_W'(1);
        2'b01:   count <= count - QCOUNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == '0) begin
          slot[0] <= push_item;
        end else begin
          slot[1] <= push_item;
        end
      end
      2'b01: begin
        slot[0] <= slot[1];
      end
      2'b11: begin
        // push only allowed below full, so one entry was held
        slot[0] <= push_item;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != QCOUNT_W'(QUEUE_DEPTH))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### src/mrfc_back.sv
// Back end: CRC, trailing bytes, payload store, end-of-frame check and result register.
`default_nettype none

module mrfc_back
  import mrfc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [KIND_W-1:0]  frame_kind,
  input  wire logic               q_valid,
  input  wire byte_item_t         q_item,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output status_t                 out_status,
  output logic [COUNT_W-1:0]      out_len,
  output logic [VALUE_W-1:0]      out_va,
  output logic [VALUE_W-1:0]      out_vb,
  output logic [VALUE_W-1:0]      out_vc,
  output logic [VALUE_W-1:0]      out_vd
);

  logic [15:0]  crc;
  logic [15:0]  crc_next;
  logic [15:0]  crc_upd;
  logic [7:0]   trail0;
  logic [7:0]   trail1;
  logic [7:0]   payload [PAYLOAD_BYTES];
  logic [15:0]  rx_crc;
  logic         load;
  status_t      status;
  logic [VALUE_W-1:0] va, vb, vc, vd;

  // Non-last bytes never wait; last bytes wait for the result slot.
  assign pop  = q_valid && (!q_item.last || !out_valid || out_ready);
  assign load = pop && q_item.last;

  always_comb begin
    crc_upd = q_item.crc_en ? crc_byte(crc, trail0) : crc;
    rx_crc  = {q_item.data, trail1};
    crc_next = crc_upd;
    if (q_item.len != kind_size(frame_kind)) begin
      status = STATUS_BAD_SIZE;
    end else if (rx_crc != crc_upd) begin
      status = STATUS_BAD_CRC;
    end else begin
      status = STATUS_OK;
    end
    va = '0;
    vb = '0;
    vc = '0;
    vd = '0;
    if (status == STATUS_OK) begin
      case (frame_kind)
        KIND_THREE_BYTE: begin
          va = dec3(payload[0], payload[1], payload[2]);
        end
        KIND_THREE_X3: begin
          va = dec3(payload[0], payload[1], payload[2]);
          vb = dec3(payload[3], payload[4], payload[5]);
          vc = dec3(payload[6], payload[7], payload[8]);
        end
        KIND_FOUR_X3: begin
          va = dec3(payload[0], payload[1], payload[2]);
          vb = dec3(payload[3], payload[4], payload[5]);
          vc = dec3(payload[6], payload[7], payload[8]);
          vd = dec3(payload[9], payload[10], payload[11]);
        end
        KIND_FOUR_X4: begin
          va = dec4(payload[0], payload[1], payload[2], payload[3]);
          vb = dec4(payload[4], payload[5], payload[6], payload[7]);
          vc = dec4(payload[8], payload[9], payload[10], payload[11]);
          vd = dec4(payload[12], payload[13], payload[14], payload[15]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= CRC_INIT;
      trail0    <= '0;
      trail1    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (q_item.last) begin
          crc    <= CRC_INIT;
          trail0 <= '0;
          trail1 <= '0;
        end else begin
          crc    <= crc_next;
          trail0 <= trail1;
          trail1 <= q_item.data;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.store_en) begin
      payload[q_item.store_idx] <= q_item.data;
    end
    if (load) begin
      out_status <= status;
      out_len    <= q_item.len;
      out_va     <= va;
      out_vb     <= vb;
      out_vc     <= vc;
      out_vd     <= vd;
    end
  end

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("last byte taken but no result presented");
  a_crc_reload: assert property (@(posedge clk) disable iff (rst)
    load |=> crc == CRC_INIT)
    else $error("CRC not reloaded after frame end");
  a_values_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != STATUS_OK |-> out_va == '0 && out_vd == '0)
    else $error("raw values nonzero on failed frame");
`endif

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the meter response frame checker (CRC-16 frame check and decode).
`default_nettype none

module testbench;
  import mrfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Kinds outside the defined layouts; no frame size matches them.
  localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  localparam int QUIET_LIMIT   = 5000;  // cycles without any transaction
  localparam int CFG_SETTLE    = 8;     // cycles for bytes still in flight
  localparam int DRAIN_CYCLES  = 10;
  localparam int LONG_HOLD     = 300;   // receiver hold-off for the fill test
  localparam int REPORT_LIMIT  = 10;
  localparam int LONG_FRAME    = 260;   // past the byte count saturation

  typedef enum {TRAILER_GOOD, TRAILER_CORRUPT} trailer_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   frame_length;
    logic [VALUE_W-1:0]   value_a;
    logic [VALUE_W-1:0]   value_b;
    logic [VALUE_W-1:0]   value_c;
    logic [VALUE_W-1:0]   value_d;
  } meter_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [7:0]        s_tdata  = '0;
  logic              s_tlast  = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [135:0]      m_tdata;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [KIND_W-1:0] cfg_data  = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;

  always #1 clk = ~clk;

  meter_response_frame_checker u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  // ---------------------------------------------------------------------------
  // Shared test state
  // ---------------------------------------------------------------------------
  int idle_pct   = 0;   // chance per cycle that the sender holds back
  int stall_pct  = 0;   // chance per cycle that the receiver drops tready
  int hold_serial = 0;  // bumped by a test to request a long receiver hold-off
  int hold_seen   = 0;
  int hold_left   = 0;
  int mismatches  = 0;
  int bytes_sent  = 0;

  meter_result_t expected_results[$];

  // Frame tracker: mirrors the checker's per-frame state
  logic [KIND_W-1:0] kind_now = KIND_THREE_X3;
  logic [15:0]       crc_acc  = CRC_INIT;
  int                byte_pos = 0;
  logic [7:0]        tail_old = '0;
  logic [7:0]        tail_new = '0;
  logic [7:0]        payload [PAYLOAD_BYTES];

  // ---------------------------------------------------------------------------
  // CRC and field decode
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic int frame_bytes(input logic [KIND_W-1:0] k);
    case (k)
      KIND_ONE_BYTE:   return 4;
      KIND_THREE_BYTE: return 6;
      KIND_THREE_X3:   return 12;
      KIND_FOUR_X3:    return 15;
      KIND_FOUR_X4:    return 19;
      default:         return 0;
    endcase
  endfunction

  // b0 b1 b2 -> b0 low six bits on top, then b2, then b1
  function automatic logic [VALUE_W-1:0] raw3(input int at);
    logic [7:0] top;
    top = payload[at] & FIELD_MASK;
    return {8'h00, top[5:0], payload[at + 2], payload[at + 1]};
  endfunction

  // b0 b1 b2 b3 -> b1 low six bits, b0, b3, b2
  function automatic logic [VALUE_W-1:0] raw4(input int at);
    logic [7:0] top;
    top = payload[at + 1] & FIELD_MASK;
    return {top[5:0], payload[at], payload[at + 3], payload[at + 2]};
  endfunction

  // Advance the tracker by one accepted byte; a last byte queues one result.
  task automatic track_byte(input logic [7:0] b, input logic is_last);
    meter_result_t r;
    if (byte_pos >= 2) crc_acc = crc_step(crc_acc, tail_old);
    tail_old = tail_new;
    tail_new = b;
    if (byte_pos >= 1 && byte_pos <= PAYLOAD_BYTES) payload[byte_pos - 1] = b;
    if (byte_pos < MAX_FRAME) byte_pos++;
    if (is_last) begin
      r = '0;
      r.frame_length = COUNT_W'(byte_pos);
      // size check wins over the CRC check
      if (byte_pos != frame_bytes(kind_now)) begin
        r.status = STATUS_BAD_SIZE;
      end else if ({tail_new, tail_old} != crc_acc) begin
        r.status = STATUS_BAD_CRC;
      end else begin
        r.status = STATUS_OK;
        case (kind_now)
          KIND_THREE_BYTE: begin
            r.value_a = raw3(0);
          end
          KIND_THREE_X3: begin
            r.value_a = raw3(0);
            r.value_b = raw3(3);
            r.value_c = raw3(6);
          end
          KIND_FOUR_X3: begin
            r.value_a = raw3(0);
            r.value_b = raw3(3);
            r.value_c = raw3(6);
            r.value_d = raw3(9);
          end
          KIND_FOUR_X4: begin
            r.value_a = raw4(0);
            r.value_b = raw4(4);
            r.value_c = raw4(8);
            r.value_d = raw4(12);
          end
          default: begin
          end
        endcase
      end
      expected_results.push_back(r);
      crc_acc  = CRC_INIT;
      byte_pos = 0;
      tail_old = '0;
      tail_new = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte sender: random idle cycles, then hold the byte until the transaction.
  // valid stays high across back-to-back bytes; callers drop it at phase end.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    track_byte(b, is_last);
    bytes_sent++;
  endtask

  task automatic sender_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Frame of n bytes; for n >= 2 the last two carry the CRC low byte first,
  // optionally with one bit flipped. fill < 0 gives random body bytes.
  task automatic send_frame(input int n, input trailer_t tr, input int fill);
    logic [7:0]  b;
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      if (n >= 2 && i == n - 2) begin
        if (tr == TRAILER_CORRUPT) c = c ^ 16'(1 << $urandom_range(15));
        b = c[7:0];
      end else if (n >= 2 && i == n - 1) begin
        b = c[15:8];
      end else begin
        b = (fill < 0) ? 8'($urandom) : 8'(fill);
        c = crc_step(c, b);
      end
      send_byte(b, i == n - 1);
    end
  endtask

  // Configuration only while the checker is idle: all results back, plus a
  // settling wait for bytes of an unfinished frame still in the pipeline.
  task automatic write_frame_kind(input logic [KIND_W-1:0] k);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    kind_now = k;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off counted here when requested
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_serial != hold_seen) begin
      hold_seen <= hold_serial;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    meter_result_t got;
    meter_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status       = status_t'(m_tdata[1:0]);
      got.frame_length = m_tdata[9:2];
      got.value_a      = m_tdata[39:10];
      got.value_b      = m_tdata[69:40];
      got.value_c      = m_tdata[99:70];
      got.value_d      = m_tdata[129:100];
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d len %0d",
                                  got.status, got.frame_length));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.frame_length !== want.frame_length ||
            got.value_a !== want.value_a || got.value_b !== want.value_b ||
            got.value_c !== want.value_c || got.value_d !== want.value_d) begin
          report_mismatch($sformatf(
            "exp st %0d len %0d a %h b %h c %h d %h / got st %0d len %0d a %h b %h c %h d %h",
            want.status, want.frame_length, want.value_a, want.value_b, want.value_c,
            want.value_d, got.status, got.frame_length, got.value_a, got.value_b,
            got.value_c, got.value_d));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transaction ends the run
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[meter_response_frame_checker] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset kind is three by three: clean frames with flat and random bodies, a bad CRC.
  task automatic test_reset_kind();
    send_frame(12, TRAILER_GOOD, 8'h00);
    send_frame(12, TRAILER_GOOD, 8'hFF);
    send_frame(12, TRAILER_GOOD, -1);
    send_frame(12, TRAILER_CORRUPT, -1);
    sender_quiet();
  endtask

  // Each defined kind: clean, bad CRC, and a size mismatch that also has a bad CRC.
  task automatic test_each_kind();
    for (int k = KIND_ONE_BYTE; k <= KIND_FOUR_X4; k++) begin
      write_frame_kind(KIND_W'(k));
      send_frame(frame_bytes(kind_now), TRAILER_GOOD, -1);
      send_frame(frame_bytes(kind_now), TRAILER_CORRUPT, -1);
      send_frame(frame_bytes(kind_now) + 1, TRAILER_CORRUPT, -1);
      sender_quiet();
    end
  endtask

  // Kinds past the defined layouts always report a size error.
  task automatic test_spare_kinds();
    write_frame_kind(KIND_SPARE_5);
    send_frame(12, TRAILER_GOOD, -1);
    sender_quiet();
    write_frame_kind(KIND_SPARE_6);
    send_frame(4, TRAILER_GOOD, -1);
    sender_quiet();
    write_frame_kind(KIND_SPARE_7);
    send_frame(19, TRAILER_GOOD, -1);
    sender_quiet();
  endtask

  // One- and two-byte frames use zero for the missing trailer bytes; a frame
  // past 255 bytes saturates the count; a clean frame after it must decode.
  task automatic test_short_and_long();
    write_frame_kind(KIND_FOUR_X4);
    send_frame(1, TRAILER_GOOD, -1);
    send_frame(2, TRAILER_GOOD, -1);
    send_frame(3, TRAILER_GOOD, -1);
    send_frame(LONG_FRAME, TRAILER_GOOD, -1);
    send_frame(19, TRAILER_GOOD, -1);
    sender_quiet();
  endtask

  // Receiver holds off for a long stretch while one-byte frames keep coming,
  // so results back up and the input side stalls.
  task automatic test_backpressure();
    write_frame_kind(KIND_ONE_BYTE);
    hold_serial++;
    repeat (30) send_byte(8'($urandom), 1'b1);
    repeat (4) send_frame(4, TRAILER_GOOD, -1);
    sender_quiet();
  endtask

  // Random traffic across idle/stall phases; mostly clean frames for the
  // current kind, some bad CRC, wrong sizes and loose byte noise.
  task automatic test_random_traffic();
    int idle_set [4];
    int stall_set [4];
    int start;
    int pick;
    idle_set  = '{0, 61, 0, 20};
    stall_set = '{0, 0, 61, 20};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int s = 0; s < 2; s++) begin
        if (ph == 0 && s == 0) begin
          write_frame_kind(KIND_ONE_BYTE);
        end else if (ph == 1 && s == 0) begin
          write_frame_kind(KIND_FOUR_X4);
        end else begin
          write_frame_kind(KIND_W'($urandom_range(KIND_FOUR_X4, KIND_ONE_BYTE)));
        end
        start = bytes_sent;
        while (bytes_sent - start < 52) begin
          pick = $urandom_range(99);
          if (pick < 70) begin
            send_frame(frame_bytes(kind_now), TRAILER_GOOD, -1);
          end else if (pick < 80) begin
            send_frame(frame_bytes(kind_now), TRAILER_CORRUPT, -1);
          end else if (pick < 90) begin
            send_frame($urandom_range(24, 1), TRAILER_GOOD, -1);
          end else begin
            // loose bytes, closed by a last byte so the next frame starts clean
            repeat ($urandom_range(7, 0)) send_byte(8'($urandom), $urandom_range(3) == 0);
            send_byte(8'($urandom), 1'b1);
          end
        end
        sender_quiet();
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < PAYLOAD_BYTES; i++) payload[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_kind();
    test_each_kind();
    test_spare_kinds();
    test_short_and_long();
    test_backpressure();
    test_random_traffic();

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[meter_response_frame_checker] OK");
    end else begin
      $display("[meter_response_frame_checker] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### meter_response_frame_checker.f
src/mrfc_pkg.sv
src/mrfc_front.sv
src/mrfc_queue.sv
src/mrfc_back.sv
src/meter_response_frame_checker.sv
test/testbench.sv
